### sv/lsdb_pkg.sv
// Shared constants and types for the link-state database install block.
package lsdb_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int KEY_W       = 32;
   localparam int SEQ_W       = 32;

   // Event codes reported in event_res.
   typedef enum logic [3:0] {
      EV_SELF_DUP     = 4'd0,
      EV_SELF_FRESH   = 4'd1,
      EV_SELF_NEWER   = 4'd2,
      EV_SELF_OLDER   = 4'd3,
      EV_REMOTE_DUP   = 4'd4,
      EV_REMOTE_FRESH = 4'd5,
      EV_REMOTE_NEWER = 4'd6,
      EV_REMOTE_OLDER = 4'd7,
      EV_REMOVED      = 4'd8,
      EV_NOT_FOUND    = 4'd9,
      EV_IMPOSSIBLE   = 4'd10,
      EV_FULL         = 4'd11
   } event_type;

   // Actions reported in action.
   typedef enum logic [2:0] {
      ACT_NONE     = 3'd0,
      ACT_ADD_ALL  = 3'd1,
      ACT_REPL_ALL = 3'd2,
      ACT_ADD_EXC  = 3'd3,
      ACT_REPL_EXC = 3'd4,
      ACT_REGEN    = 3'd5,
      ACT_RETURN   = 3'd6
   } action_type;

   // Classes of an install against the stored entry; the order matches the
   // offset of the event code within the self and remote groups.
   typedef enum logic [1:0] {
      CLS_DUP   = 2'd0,
      CLS_FRESH = 2'd1,
      CLS_NEWER = 2'd2,
      CLS_OLDER = 2'd3
   } class_type;

   // Lookup token that walks the row of cells, one cell per cycle.
   typedef struct packed {
      logic             active;
      logic             hit;
      logic [IDX_W-1:0] hit_idx;
      logic [SEQ_W-1:0] hit_seq;
      logic             space;
      logic [IDX_W-1:0] free_idx;
   } token_type;

   // Write command broadcast from the controller to every cell.
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic             wr_key;
      logic             wr_seq;
      logic             valid;
      logic [KEY_W-1:0] key;
      logic [SEQ_W-1:0] seq;
   } wr_type;

endpackage

### sv/lsdb_cell.sv
// One table cell: holds one entry and passes the lookup token to its neighbor.
module lsdb_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [lsdb_pkg::IDX_W-1:0] cell_idx,
   input  logic [lsdb_pkg::KEY_W-1:0] lookup_key,
   input  lsdb_pkg::token_type       tok_in,
   output lsdb_pkg::token_type       tok_out,
   input  lsdb_pkg::wr_type          wr
);

   logic [lsdb_pkg::KEY_W-1:0] key_ff;
   logic [lsdb_pkg::SEQ_W-1:0] seq_ff;
   logic                       valid_ff;
   lsdb_pkg::token_type        tok_ff, tok_in_next;
   logic                       sel;

   assign sel = wr.en && (wr.idx == cell_idx);

   // The first valid matching cell and the first free cell claim the token.
   always_comb begin
      tok_in_next = tok_in;
      if (tok_in.active) begin
         if (!tok_in.hit && valid_ff && (key_ff == lookup_key)) begin
            tok_in_next.hit     = 1'b1;
            tok_in_next.hit_idx = cell_idx;
            tok_in_next.hit_seq = seq_ff;
         end
         if (!tok_in.space && !valid_ff) begin
            tok_in_next.space    = 1'b1;
            tok_in_next.free_idx = cell_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff.active <= tok_in_next.active;
         if (sel) begin
            valid_ff <= wr.valid;
         end
      end
      tok_ff.hit      <= tok_in_next.hit;
      tok_ff.hit_idx  <= tok_in_next.hit_idx;
      tok_ff.hit_seq  <= tok_in_next.hit_seq;
      tok_ff.space    <= tok_in_next.space;
      tok_ff.free_idx <= tok_in_next.free_idx;
      if (sel && wr.wr_key) begin
         key_ff <= wr.key;
      end
      if (sel && wr.wr_seq) begin
         seq_ff <= wr.seq;
      end
   end

   assign tok_out = tok_ff;

endmodule

### sv/link_state_db_install.sv
// Top level of the link-state database install block: controller and cell row.
//
//   Channel  Direction  Payload
//   req_*    in         tdata: router_id[31:0], seq_no[63:32];
//                       tuser: command[0], via_interface[1]
//   rsp_*    out        tdata: event_res[3:0], action[6:4], stored_seq[38:7],
//                       regen_seq[70:39], zero pad[71]
//   csr_*    in         own_router_id, written when csr_we is high
//
// For each item the lookup token walks the row of cells one cell per cycle; then
// done_ff captures it, and the decide state, once the output register is free,
// updates the table and loads the result register.
// Reset (synchronous, active high) clears every valid bit at once, so the
// table is empty right after reset with no clearing pass.
// A result waits in its output register until taken; a new item is accepted
// as soon as the controller is idle, even while that result is still waiting.
module link_state_db_install (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // router_id[31:0], seq_no[63:32]
   input  logic [1:0]  req_tuser,   // command[0], via_interface[1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // event_res[3:0], action[6:4], stored_seq[38:7],
                                    // regen_seq[70:39], zero[71]
   input  logic        csr_we,
   input  logic [31:0] csr_wdata    // own_router_id
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_WALK   = 3'b010,
      ST_DECIDE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [31:0] own_id_ff;

   // Item held for the whole lookup.
   logic                          cmd_ff, intf_ff;
   logic [lsdb_pkg::KEY_W-1:0]    key_ff;
   logic [lsdb_pkg::SEQ_W-1:0]    seq_ff;
   logic                          start_ff;
   lsdb_pkg::token_type           done_ff;

   // Output register.
   logic                          rsp_valid_ff;
   logic [3:0]                    ev_ff, ev_in;
   logic [2:0]                    act_ff, act_in;
   logic [lsdb_pkg::SEQ_W-1:0]    stored_ff, stored_in;
   logic [lsdb_pkg::SEQ_W-1:0]    regen_ff, regen_in;

   lsdb_pkg::token_type           tok [lsdb_pkg::TABLE_DEPTH+1];
   lsdb_pkg::wr_type              wr, wr_dec;
   lsdb_pkg::token_type           tail;

   logic       req_fire, out_free, fire;
   logic       self_id;
   logic [1:0] cls;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = (state_ff == ST_DECIDE) && out_free;
   assign tail       = tok[lsdb_pkg::TABLE_DEPTH];

   // The token enters the first cell in the cycle after the item is taken.
   always_comb begin
      tok[0]        = '0;
      tok[0].active = start_ff;
   end

   for (genvar i = 0; i < lsdb_pkg::TABLE_DEPTH; i++) begin : g_cell
      lsdb_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_idx   (lsdb_pkg::IDX_W'(i)),
         .lookup_key (key_ff),
         .tok_in     (tok[i]),
         .tok_out    (tok[i+1]),
         .wr         (wr)
      );
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_WALK;
         ST_WALK:   if (tail.active) state_in = ST_DECIDE;
         ST_DECIDE: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Classification of the item against what the walk found.
   always_comb begin
      self_id   = (key_ff == own_id_ff);
      stored_in = done_ff.hit ? done_ff.hit_seq : '0;
      if (!done_ff.hit) begin
         cls = lsdb_pkg::CLS_FRESH;
      end else if (seq_ff == done_ff.hit_seq) begin
         cls = lsdb_pkg::CLS_DUP;
      end else if (seq_ff > done_ff.hit_seq) begin
         cls = lsdb_pkg::CLS_NEWER;
      end else begin
         cls = lsdb_pkg::CLS_OLDER;
      end

      ev_in    = lsdb_pkg::EV_SELF_DUP;
      act_in   = lsdb_pkg::ACT_NONE;
      regen_in = '0;
      wr_dec   = '0;
      wr_dec.key = key_ff;
      wr_dec.seq = seq_ff;

      if (cmd_ff) begin
         if (done_ff.hit) begin
            ev_in      = lsdb_pkg::EV_REMOVED;
            wr_dec.en  = 1'b1;
            wr_dec.idx = done_ff.hit_idx;
         end else begin
            ev_in = lsdb_pkg::EV_NOT_FOUND;
         end
      end else begin
         ev_in = {1'b0, !self_id, cls};
         if (self_id && intf_ff) begin
            // Our own entry came back from the network: regenerate it if fresh or newer.
            if (cls == lsdb_pkg::CLS_FRESH || cls == lsdb_pkg::CLS_NEWER) begin
               act_in   = lsdb_pkg::ACT_REGEN;
               regen_in = seq_ff + 32'd1;
            end
         end else if (!self_id && !intf_ff) begin
            ev_in = lsdb_pkg::EV_IMPOSSIBLE;
         end else begin
            case (cls)
               lsdb_pkg::CLS_DUP: begin
                  if (!intf_ff) ev_in = lsdb_pkg::EV_IMPOSSIBLE;
               end
               lsdb_pkg::CLS_FRESH: begin
                  if (!done_ff.space) begin
                     ev_in = lsdb_pkg::EV_FULL;
                  end else begin
                     wr_dec.en     = 1'b1;
                     wr_dec.idx    = done_ff.free_idx;
                     wr_dec.wr_key = 1'b1;
                     wr_dec.wr_seq = 1'b1;
                     wr_dec.valid  = 1'b1;
                     act_in        = self_id ? lsdb_pkg::ACT_ADD_ALL
                                             : lsdb_pkg::ACT_ADD_EXC;
                  end
               end
               lsdb_pkg::CLS_NEWER: begin
                  wr_dec.en     = 1'b1;
                  wr_dec.idx    = done_ff.hit_idx;
                  wr_dec.wr_seq = 1'b1;
                  wr_dec.valid  = 1'b1;
                  act_in        = self_id ? lsdb_pkg::ACT_REPL_ALL
                                          : lsdb_pkg::ACT_REPL_EXC;
               end
               default: begin
                  if (self_id) ev_in = lsdb_pkg::EV_IMPOSSIBLE;
                  else         act_in = lsdb_pkg::ACT_RETURN;
               end
            endcase
         end
      end
   end

   always_comb begin
      wr    = wr_dec;
      wr.en = wr_dec.en && fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         own_id_ff    <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= req_fire;
         if (csr_we) begin
            own_id_ff <= csr_wdata;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff  <= req_tuser[0];
         intf_ff <= req_tuser[1];
         key_ff  <= req_tdata[31:0];
         seq_ff  <= req_tdata[63:32];
      end
      if (state_ff == ST_WALK && tail.active) begin
         done_ff <= tail;
      end
      if (fire) begin
         ev_ff     <= ev_in;
         act_ff    <= act_in;
         stored_ff <= stored_in;
         regen_ff  <= regen_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, regen_ff, stored_ff, act_ff, ev_ff};

endmodule
